// ----- rtl/essrc_pkg.sv -----
// ----------------------------------------------------------------------------
// essrc_pkg
// Shared types, byte codes and helpers for the scroll-band escape filter.
// ----------------------------------------------------------------------------
package essrc_pkg;

  // Parser mode, kept between beats.
  typedef enum logic [2:0] {
    MODE_GROUND,
    MODE_ESC,
    MODE_CSI,
    MODE_STR,
    MODE_STR_ESC
  } mode_e;

  // Output sequencer.
  typedef enum logic [1:0] {
    S_IDLE,
    S_TAIL,
    S_FLUSH,
    S_CLAMP
  } state_e;

  // Configuration register indexes.
  localparam logic CFG_BAND_TOP    = 1'b0;
  localparam logic CFG_BAND_BOTTOM = 1'b1;

  // Byte codes.
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_BEL    = 8'h07;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_LOW_R  = 8'h72;
  localparam logic [7:0] BYTE_SEVEN  = 8'h37;
  localparam logic [7:0] BYTE_EIGHT  = 8'h38;
  localparam logic [7:0] BYTE_SEMI   = 8'h3B;
  localparam logic [7:0] BYTE_OSC    = 8'h5D;
  localparam logic [7:0] BYTE_DCS    = 8'h50;
  localparam logic [7:0] BYTE_SOS    = 8'h58;
  localparam logic [7:0] BYTE_PM     = 8'h5E;
  localparam logic [7:0] BYTE_APC    = 8'h5F;
  localparam logic [7:0] PARAM_LO    = 8'h20;
  localparam logic [7:0] PARAM_HI    = 8'h3F;
  localparam logic [2:0] PARAM_BASE  = 3'b001;
  localparam logic [3:0] DIGIT_BASE  = 4'h3;

  // Slots of the clamp sequence: ESC 7 ESC [ tttt ; bbbb r ESC 8
  localparam logic [3:0] CLAMP_ESC0   = 4'd0;
  localparam logic [3:0] CLAMP_SEVEN  = 4'd1;
  localparam logic [3:0] CLAMP_ESC1   = 4'd2;
  localparam logic [3:0] CLAMP_LBRACK = 4'd3;
  localparam logic [3:0] CLAMP_TOP3   = 4'd4;
  localparam logic [3:0] CLAMP_TOP2   = 4'd5;
  localparam logic [3:0] CLAMP_TOP1   = 4'd6;
  localparam logic [3:0] CLAMP_TOP0   = 4'd7;
  localparam logic [3:0] CLAMP_SEMI   = 4'd8;
  localparam logic [3:0] CLAMP_BOT3   = 4'd9;
  localparam logic [3:0] CLAMP_BOT2   = 4'd10;
  localparam logic [3:0] CLAMP_BOT1   = 4'd11;
  localparam logic [3:0] CLAMP_BOT0   = 4'd12;
  localparam logic [3:0] CLAMP_R      = 4'd13;
  localparam logic [3:0] CLAMP_ESC2   = 4'd14;
  localparam logic [3:0] CLAMP_EIGHT  = 4'd15;

  localparam logic [15:0] BCD_TOP_RST    = 16'h0002;
  localparam logic [15:0] BCD_BOTTOM_RST = 16'h0023;

  // Shift-and-add-3 conversion of a 10-bit value into four BCD digits.
  function automatic logic [15:0] bin_to_bcd(input logic [9:0] v);
    logic [25:0] sh;
    sh = {16'h0000, v};
    for (int i = 0; i < 10; i++) begin
      for (int d = 0; d < 4; d++) begin
        if (sh[10 + 4*d +: 4] > 4'd4) begin
          sh[10 + 4*d +: 4] = sh[10 + 4*d +: 4] + 4'd3;
        end
      end
      sh = sh << 1;
    end
    return sh[25:10];
  endfunction

  // Number of printed digits, leading zeros dropped, at least one.
  function automatic logic [2:0] bcd_digits(input logic [15:0] bcd);
    if (bcd[15:12] != 4'h0) begin
      return 3'd4;
    end else if (bcd[11:8] != 4'h0) begin
      return 3'd3;
    end else if (bcd[7:4] != 4'h0) begin
      return 3'd2;
    end
    return 3'd1;
  endfunction

endpackage

// ----- rtl/escape_stream_scroll_region_clamp.sv -----
// ----------------------------------------------------------------------------
// escape_stream_scroll_region_clamp
// Terminal byte filter that rewrites scroll-region CSIs to a fixed band.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one byte of the child's
//   output per beat, or an end-of-stream beat that flushes held bytes.
//   Output channel (out_valid_o/out_ready_i) carries one filtered byte per
//   beat; last_of_run_o marks the final byte caused by an input beat, and
//   seq_overflow_o flags bytes of a CSI that outgrew the parameter store.
//   An input beat may cause no output at all (held ESC or CSI bytes).
// Sequencing:
//   A plain byte is registered and appears in the cycle after acceptance.
//   Escape pairs, clamp rewrites and verbatim CSI flushes are run out by
//   the sequencer, which walks the parameter memory one entry per cycle
//   while the output is not stalled (one read port, registered read).
//   Input is held off while a run is emitted.
// Reset:
//   Parser returns to ground, band registers load 2 and 23. The parameter
//   memory is not cleared; only entries written by the current CSI are read.
// Stall:
//   The output register holds its byte while out_ready_i is low; the
//   sequencer and input side wait with it.
// ----------------------------------------------------------------------------
module escape_stream_scroll_region_clamp
  import essrc_pkg::*;
#(
  parameter int MAX_CSI_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [9:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       seq_overflow_o
);

  localparam int AW = $clog2(MAX_CSI_LEN);
  localparam int CW = $clog2(MAX_CSI_LEN + 1);
  localparam int PW = $clog2(MAX_CSI_LEN + 3);

  // Band registers, kept in BCD so the rewrite needs no conversion.
  logic [15:0] top_bcd_q, bot_bcd_q;
  logic [2:0]  top_n, bot_n;

  // Parser state.
  mode_e       mode_q, mode_d;
  logic [CW-1:0] count_q, count_d;
  logic        ovf_q, ovf_d;

  // Sequencer state.
  state_e      state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [3:0]  step_q, step_d;
  logic [7:0]  tail_q, tail_d;
  logic        flag_q, flag_d;
  logic        has_tail_q, has_tail_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic        out_ovf_q, out_ovf_d;

  // Parameter memory.
  logic [4:0]  param_mem [MAX_CSI_LEN];
  logic [4:0]  rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [4:0]  mem_wdata;

  logic          out_free, in_fire, esc_follow, is_param, is_str_intro;
  logic          emit;
  logic [7:0]    e_byte;
  logic          e_last, e_flag;
  logic [PW-1:0] rd_idx, rd_idx_next, last_pos;
  logic [1:0]    dig_idx;

  assign top_n = bcd_digits(top_bcd_q);
  assign bot_n = bcd_digits(bot_bcd_q);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_param     = (in_byte_i >= PARAM_LO) && (in_byte_i <= PARAM_HI);
  assign is_str_intro = (in_byte_i == BYTE_OSC) || (in_byte_i == BYTE_DCS) ||
                        (in_byte_i == BYTE_SOS) || (in_byte_i == BYTE_PM) ||
                        (in_byte_i == BYTE_APC);

  assign rd_idx   = pos_q - PW'(2);
  assign last_pos = PW'(count_q) + PW'(1) + PW'(has_tail_q);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_bcd_q <= BCD_TOP_RST;
      bot_bcd_q <= BCD_BOTTOM_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BAND_TOP:    top_bcd_q <= bin_to_bcd(cfg_data_i);
        CFG_BAND_BOTTOM: bot_bcd_q <= bin_to_bcd(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Next state, emit selection and memory control.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    step_d      = step_q;
    tail_d      = tail_q;
    flag_d      = flag_q;
    has_tail_d  = has_tail_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[AW-1:0];
    mem_wdata   = in_byte_i[4:0];
    emit        = 1'b0;
    e_byte      = BYTE_ESC;
    e_last      = 1'b0;
    e_flag      = 1'b0;
    esc_follow  = 1'b0;
    dig_idx     = 2'd0;

    case (state_q)
      S_IDLE: begin
        if (in_fire && end_of_stream_i) begin
          // Flush what is held, then back to ground.
          mode_d = MODE_GROUND;
          ovf_d  = 1'b0;
          if (mode_q == MODE_ESC || mode_q == MODE_STR_ESC) begin
            emit   = 1'b1;
            e_last = 1'b1;
          end else if (mode_q == MODE_CSI && !ovf_q) begin
            emit       = 1'b1;
            state_d    = S_FLUSH;
            pos_d      = PW'(1);
            flag_d     = 1'b0;
            has_tail_d = 1'b0;
          end
        end else if (in_fire) begin
          case (mode_q)
            MODE_GROUND: begin
              if (in_byte_i == BYTE_ESC) begin
                mode_d = MODE_ESC;
              end else begin
                emit   = 1'b1;
                e_byte = in_byte_i;
                e_last = 1'b1;
              end
            end
            MODE_ESC: esc_follow = 1'b1;
            MODE_CSI: begin
              if (is_param && ovf_q) begin
                emit   = 1'b1;
                e_byte = in_byte_i;
                e_last = 1'b1;
                e_flag = 1'b1;
              end else if (is_param && (count_q < CW'(MAX_CSI_LEN))) begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end else if (is_param) begin
                // Store full: flush verbatim, flagged, and pass the rest.
                emit       = 1'b1;
                e_flag     = 1'b1;
                state_d    = S_FLUSH;
                pos_d      = PW'(1);
                flag_d     = 1'b1;
                has_tail_d = 1'b1;
                tail_d     = in_byte_i;
                ovf_d      = 1'b1;
              end else begin
                mode_d = MODE_GROUND;
                ovf_d  = 1'b0;
                if (ovf_q) begin
                  emit   = 1'b1;
                  e_byte = in_byte_i;
                  e_last = 1'b1;
                  e_flag = 1'b1;
                end else if (in_byte_i == BYTE_LOW_R) begin
                  emit    = 1'b1;
                  state_d = S_CLAMP;
                  step_d  = CLAMP_SEVEN;
                end else begin
                  emit       = 1'b1;
                  state_d    = S_FLUSH;
                  pos_d      = PW'(1);
                  flag_d     = 1'b0;
                  has_tail_d = 1'b1;
                  tail_d     = in_byte_i;
                end
              end
            end
            MODE_STR: begin
              if (in_byte_i == BYTE_ESC) begin
                mode_d = MODE_STR_ESC;
              end else begin
                emit   = 1'b1;
                e_byte = in_byte_i;
                e_last = 1'b1;
                if (in_byte_i == BYTE_BEL) begin
                  mode_d = MODE_GROUND;
                end
              end
            end
            MODE_STR_ESC: begin
              if (in_byte_i == BYTE_BSLASH) begin
                emit    = 1'b1;
                state_d = S_TAIL;
                tail_d  = in_byte_i;
                flag_d  = 1'b0;
                mode_d  = MODE_GROUND;
              end else begin
                // Unterminated string: the ESC opens a new escape.
                esc_follow = 1'b1;
              end
            end
            default: begin
              mode_d  = MODE_GROUND;
              count_d = '0;
              ovf_d   = 1'b0;
            end
          endcase

          if (esc_follow) begin
            if (in_byte_i == BYTE_LBRACK) begin
              mode_d  = MODE_CSI;
              count_d = '0;
              ovf_d   = 1'b0;
            end else begin
              emit    = 1'b1;
              state_d = S_TAIL;
              tail_d  = in_byte_i;
              flag_d  = 1'b0;
              mode_d  = is_str_intro ? MODE_STR : MODE_GROUND;
            end
          end
        end
      end

      S_TAIL: begin
        if (out_free) begin
          emit    = 1'b1;
          e_byte  = tail_q;
          e_last  = 1'b1;
          e_flag  = flag_q;
          state_d = S_IDLE;
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          emit   = 1'b1;
          e_flag = flag_q;
          e_last = (pos_q == last_pos);
          if (pos_q == PW'(1)) begin
            e_byte = BYTE_LBRACK;
          end else if (rd_idx < PW'(count_q)) begin
            e_byte = {PARAM_BASE, rdata_q};
          end else begin
            e_byte = tail_q;
          end
          pos_d = pos_q + PW'(1);
          if (e_last) begin
            state_d = S_IDLE;
          end
        end
      end

      S_CLAMP: begin
        if (out_free) begin
          emit   = 1'b1;
          step_d = step_q + 4'd1;
          case (step_q)
            CLAMP_ESC0, CLAMP_ESC1, CLAMP_ESC2: e_byte = BYTE_ESC;
            CLAMP_SEVEN: e_byte = BYTE_SEVEN;
            CLAMP_LBRACK: begin
              e_byte = BYTE_LBRACK;
              // Skip the leading zeros of the top row.
              step_d = CLAMP_SEMI - {1'b0, top_n};
            end
            CLAMP_TOP3, CLAMP_TOP2, CLAMP_TOP1, CLAMP_TOP0: begin
              dig_idx = ~step_q[1:0];
              e_byte  = {DIGIT_BASE, top_bcd_q[4*dig_idx +: 4]};
            end
            CLAMP_SEMI: begin
              e_byte = BYTE_SEMI;
              step_d = CLAMP_R - {1'b0, bot_n};
            end
            CLAMP_BOT3, CLAMP_BOT2, CLAMP_BOT1, CLAMP_BOT0: begin
              dig_idx = 2'(CLAMP_BOT0 - step_q);
              e_byte  = {DIGIT_BASE, bot_bcd_q[4*dig_idx +: 4]};
            end
            CLAMP_R: e_byte = BYTE_LOW_R;
            CLAMP_EIGHT: begin
              e_byte  = BYTE_EIGHT;
              e_last  = 1'b1;
              state_d = S_IDLE;
            end
            default: e_byte = BYTE_ESC;
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Read address tracks the flush position of the next cycle.
  assign rd_idx_next = pos_d - PW'(2);
  assign mem_raddr   = (pos_d >= PW'(2) && rd_idx_next < PW'(MAX_CSI_LEN)) ?
                       rd_idx_next[AW-1:0] : '0;

  // Output register: load on emit, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = e_byte;
      out_last_d  = e_last;
      out_ovf_d   = e_flag;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Parameter store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      param_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= param_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_GROUND;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      pos_q       <= '0;
      step_q      <= CLAMP_ESC0;
      has_tail_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      pos_q       <= pos_d;
      step_q      <= step_d;
      has_tail_q  <= has_tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q     <= tail_d;
    flag_q     <= flag_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_run_o  = out_last_q;
  assign seq_overflow_o = out_ovf_q;

  // The held parameter count never passes the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_CSI_LEN))
    else $error("parameter count beyond store depth");

  // A flush position stays between the bracket and the last byte.
  a_flush_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> (pos_q >= PW'(1)) && (pos_q <= last_pos))
    else $error("flush position out of range");

  // An overflowed CSI keeps the parser in CSI mode.
  a_ovf_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (mode_q == MODE_CSI))
    else $error("overflow flag outside CSI");

  // A byte that is not the end of its run leaves the sequencer busy.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (state_q != S_IDLE))
    else $error("run cut short");

  // Accepting a byte that starts a rewrite puts the band's first ESC out.
  a_clamp_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d == S_CLAMP) |=>
      (out_valid_q && out_byte_q == BYTE_ESC && !out_ovf_q))
    else $error("clamp rewrite did not open with ESC");

endmodule

// ----- sim/tb_escape_stream_scroll_region_clamp.sv -----
// ----------------------------------------------------------------------------
// tb_escape_stream_scroll_region_clamp
// Self-checking bench for the scroll-band escape filter.
// ----------------------------------------------------------------------------
// A queue of byte beats feeds a clocked driver, and a clocked monitor pulls
// filtered beats out. On every accepted input beat a behavioral copy of the
// parser computes the filtered bytes it must cause. The monitor compares each
// output beat, field by field, against the oldest of those bytes.
// The stimulus starts with a short directed run: plain bytes, a clamped
// private CSI, a verbatim CSI, string pass-through with both terminators, a
// string cut short by a new escape, and end-of-stream flushes. After that come
// several band settings, extremes included. Each setting opens with a CSI that
// spills the store, then runs a random mix of escape sequences with random
// content, end-of-stream beats and noise. Both sides idle at random but in the
// burst phase, and one long receiver stall backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_escape_stream_scroll_region_clamp;
  import essrc_pkg::*;

  localparam int          CLK_PERIOD   = 20;
  localparam int          CSI_DEPTH    = 32;
  localparam int          SETTLE_CYC   = 40;
  localparam int          PHASE_ITEMS  = 84;
  localparam int          HOLD_AT_BEAT = 120;
  localparam int          HOLD_CYC     = 400;
  localparam logic [7:0]  BYTE_ZERO    = 8'h30;
  localparam logic [7:0]  BYTE_LOW_M   = 8'h6D;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } feed_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } out_beat_t;

  // Drive every input to a known value from time zero.
  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       cfg_we_i        = 1'b0;
  logic       cfg_index_i     = CFG_BAND_TOP;
  logic [9:0] cfg_data_i      = '0;
  logic       in_valid_i      = 1'b0;
  logic [7:0] in_byte_i       = '0;
  logic       end_of_stream_i = 1'b0;
  logic       out_ready_i     = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;
  logic       seq_overflow_o;

  // Beats waiting to be offered, and filtered bytes waiting to come out.
  feed_item_t  byte_feed_q[$];
  out_beat_t   filtered_q[$];
  int unsigned fed_items;
  int unsigned errors;
  bit          burst_mode;

  // Behavioral parser state, band copy included.
  mode_e       flt_mode;
  logic [4:0]  held_params[CSI_DEPTH];
  int unsigned held_cnt;
  logic        ovf_active;
  logic [9:0]  band_top_q;
  logic [9:0]  band_bottom_q;

  escape_stream_scroll_region_clamp #(
    .MAX_CSI_LEN(CSI_DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .seq_overflow_o (seq_overflow_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Expected filtered stream
  // --------------------------------------------------------------------------

  task automatic emit_byte(input logic [7:0] b, input logic ovf);
    out_beat_t t;
    t.data = b;
    t.last = 1'b0;
    t.ovf  = ovf;
    filtered_q.insert(filtered_q.size(), t);
  endtask

  // Replay the held introducer and parameter bytes as they came in.
  task automatic emit_held_csi(input logic ovf);
    emit_byte(BYTE_ESC, ovf);
    emit_byte(BYTE_LBRACK, ovf);
    for (int k = 0; k < held_cnt; k++) begin
      emit_byte(PARAM_LO + 8'(held_params[k]), ovf);
    end
  endtask

  // Print a band row in decimal, no leading zeros, at least one digit.
  task automatic emit_decimal(input logic [9:0] v);
    int unsigned rest;
    int unsigned div;
    int unsigned d;
    bit          started;
    rest    = v;
    started = 1'b0;
    for (div = 1000; div > 0; div = div / 10) begin
      d    = rest / div;
      rest = rest - d * div;
      if (d != 0 || started || div == 1) begin
        emit_byte(8'(BYTE_ZERO + d), 1'b0);
        started = 1'b1;
      end
    end
  endtask

  task automatic reset_parser();
    flt_mode   = MODE_GROUND;
    held_cnt   = 0;
    ovf_active = 1'b0;
  endtask

  // Handle the byte after an ESC: open a CSI, or pass the pair through.
  task automatic take_escape(input logic [7:0] b);
    if (b == BYTE_LBRACK) begin
      flt_mode   = MODE_CSI;
      held_cnt   = 0;
      ovf_active = 1'b0;
    end else begin
      emit_byte(BYTE_ESC, 1'b0);
      emit_byte(b, 1'b0);
      if (b inside {BYTE_OSC, BYTE_DCS, BYTE_SOS, BYTE_PM, BYTE_APC}) begin
        flt_mode = MODE_STR;
      end else begin
        flt_mode = MODE_GROUND;
      end
    end
  endtask

  task automatic take_csi_byte(input logic [7:0] b);
    if (b >= PARAM_LO && b <= PARAM_HI) begin
      if (ovf_active) begin
        emit_byte(b, 1'b1);
      end else if (held_cnt < CSI_DEPTH) begin
        held_params[held_cnt] = 5'(b - PARAM_LO);
        held_cnt++;
      end else begin
        // Store full: spill everything flagged and pass the rest through.
        emit_held_csi(1'b1);
        emit_byte(b, 1'b1);
        ovf_active = 1'b1;
      end
    end else begin
      // Any byte outside the parameter range is the final byte.
      if (ovf_active) begin
        emit_byte(b, 1'b1);
      end else if (b == BYTE_LOW_R) begin
        emit_byte(BYTE_ESC, 1'b0);
        emit_byte(BYTE_SEVEN, 1'b0);
        emit_byte(BYTE_ESC, 1'b0);
        emit_byte(BYTE_LBRACK, 1'b0);
        emit_decimal(band_top_q);
        emit_byte(BYTE_SEMI, 1'b0);
        emit_decimal(band_bottom_q);
        emit_byte(BYTE_LOW_R, 1'b0);
        emit_byte(BYTE_ESC, 1'b0);
        emit_byte(BYTE_EIGHT, 1'b0);
      end else begin
        emit_held_csi(1'b0);
        emit_byte(b, 1'b0);
      end
      reset_parser();
    end
  endtask

  // Advance the parser by one accepted beat and queue what it must emit.
  task automatic filter_byte(input logic [7:0] b, input logic eos);
    int unsigned first;
    first = filtered_q.size();
    if (eos) begin
      if (flt_mode == MODE_ESC || flt_mode == MODE_STR_ESC) begin
        emit_byte(BYTE_ESC, 1'b0);
      end else if (flt_mode == MODE_CSI && !ovf_active) begin
        emit_held_csi(1'b0);
      end
      reset_parser();
    end else begin
      case (flt_mode)
        MODE_GROUND: begin
          if (b == BYTE_ESC) begin
            flt_mode = MODE_ESC;
          end else begin
            emit_byte(b, 1'b0);
          end
        end
        MODE_ESC: begin
          take_escape(b);
        end
        MODE_CSI: begin
          take_csi_byte(b);
        end
        MODE_STR: begin
          if (b == BYTE_ESC) begin
            flt_mode = MODE_STR_ESC;
          end else begin
            emit_byte(b, 1'b0);
            if (b == BYTE_BEL) begin
              flt_mode = MODE_GROUND;
            end
          end
        end
        MODE_STR_ESC: begin
          // ESC backslash closes the string; any other byte starts an escape.
          if (b == BYTE_BSLASH) begin
            emit_byte(BYTE_ESC, 1'b0);
            emit_byte(b, 1'b0);
            flt_mode = MODE_GROUND;
          end else begin
            take_escape(b);
          end
        end
        default: begin
          reset_parser();
        end
      endcase
    end
    // Tag the final byte caused by this beat.
    if (filtered_q.size() > first) begin
      filtered_q[$].last = 1'b1;
    end
  endtask

  // Idle draw shared by both sides: none in burst phases, else often zero.
  function automatic int unsigned draw_gap();
    if (burst_mode || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued beats, hold them until accepted, idle between them
  // --------------------------------------------------------------------------
  int unsigned feed_gap;
  feed_item_t  feed_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      in_byte_i       <= '0;
      end_of_stream_i <= 1'b0;
      feed_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        filter_byte(in_byte_i, end_of_stream_i);
      end
      // Launch only when the channel is free after this edge.
      if (!in_valid_i || in_ready_o) begin
        if (feed_gap > 0) begin
          in_valid_i <= 1'b0;
          feed_gap--;
        end else if (byte_feed_q.size() > 0) begin
          feed_item = byte_feed_q.pop_front();
          in_valid_i      <= 1'b1;
          in_byte_i       <= feed_item.data;
          end_of_stream_i <= feed_item.eos;
          feed_gap = draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each output beat, stall at random, once for a long stretch
  // --------------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned out_beats;
  out_beat_t   want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      out_beats  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected output beat: out_byte %h", out_byte_o);
          errors++;
        end else begin
          want = filtered_q.pop_front();
          if (out_byte_o !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte_o);
            errors++;
          end
          if (last_of_run_o !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, last_of_run_o);
            errors++;
          end
          if (seq_overflow_o !== want.ovf) begin
            $error("seq_overflow: expected %b, got %b", want.ovf, seq_overflow_o);
            errors++;
          end
        end
        out_beats++;
        // Back the block up once so that it stalls its input.
        stall_left = (out_beats == HOLD_AT_BEAT) ? HOLD_CYC : draw_gap();
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic feed(input logic [7:0] b, input logic eos);
    feed_item_t t;
    t.data = b;
    t.eos  = eos;
    byte_feed_q.insert(byte_feed_q.size(), t);
    fed_items++;
  endtask

  function automatic logic [7:0] pick_param();
    // Mostly digits and separators, sometimes any parameter byte.
    if ($urandom_range(0, 3) != 0) begin
      return 8'($urandom_range(8'h30, 8'h3B));
    end
    return 8'($urandom_range(PARAM_LO, PARAM_HI));
  endfunction

  function automatic logic [7:0] pick_final();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return BYTE_LOW_R;
    end else if (r < 8) begin
      return 8'($urandom_range(8'h40, 8'h7E));
    end
    // Anything outside the parameter range, controls and ESC included.
    r = $urandom_range(0, 223);
    return (r < 32) ? 8'(r) : 8'(r + 32);
  endfunction

  task automatic feed_csi(input int unsigned len, input logic [7:0] fin);
    feed(BYTE_ESC, 1'b0);
    feed(BYTE_LBRACK, 1'b0);
    repeat (len) feed(pick_param(), 1'b0);
    feed(fin, 1'b0);
  endtask

  function automatic logic [7:0] pick_opener();
    case ($urandom_range(0, 4))
      0:       return BYTE_OSC;
      1:       return BYTE_DCS;
      2:       return BYTE_SOS;
      3:       return BYTE_PM;
      default: return BYTE_APC;
    endcase
  endfunction

  task automatic feed_random_sequence();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      // Plain text.
      n = $urandom_range(1, 4);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        feed((b == BYTE_ESC) ? 8'h41 : b, 1'b0);
      end
    end else if (kind < 35) begin
      // Two-byte escape.
      b = 8'($urandom_range(8'h20, 8'h7E));
      feed(BYTE_ESC, 1'b0);
      feed((b == BYTE_LBRACK) ? BYTE_SEVEN : b, 1'b0);
    end else if (kind < 65) begin
      // CSI, now and then long enough to spill the store.
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
      feed_csi(n, pick_final());
    end else if (kind < 80) begin
      // String with random content and a random way out.
      feed(BYTE_ESC, 1'b0);
      feed(pick_opener(), 1'b0);
      n = $urandom_range(0, 8);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        feed((b == BYTE_ESC) ? 8'h41 : b, 1'b0);
      end
      n = $urandom_range(0, 4);
      if (n < 2) begin
        feed(BYTE_BEL, 1'b0);
      end else if (n < 4) begin
        feed(BYTE_ESC, 1'b0);
        feed(BYTE_BSLASH, 1'b0);
      end else begin
        feed(BYTE_ESC, 1'b0);
        feed(8'($urandom_range(0, 255)), 1'b0);
      end
    end else if (kind < 90) begin
      // End of stream, half the time in the middle of a CSI.
      if ($urandom_range(0, 1) == 0) begin
        feed(BYTE_ESC, 1'b0);
        feed(BYTE_LBRACK, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) feed(pick_param(), 1'b0);
      end
      feed(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      // Noise.
      n = $urandom_range(1, 3);
      repeat (n) feed(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic write_band(input logic idx, input logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BAND_TOP) begin
      band_top_q = val;
    end else begin
      band_bottom_q = val;
    end
  endtask

  // Wait until every queued beat is in and out, then let held work settle.
  task automatic wait_drained();
    while (byte_feed_q.size() != 0 || in_valid_i || filtered_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  initial begin
    logic [9:0]  tops[5];
    logic [9:0]  bottoms[5];
    int unsigned target;

    fed_items     = 0;
    errors        = 0;
    burst_mode    = 1'b0;
    band_top_q    = 10'd2;
    band_bottom_q = 10'd23;
    reset_parser();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed run at the reset band.
    feed(8'hFF, 1'b0);
    feed(8'h00, 1'b0);
    // Private CSI ending in r: clamp all the same.
    feed(BYTE_ESC, 1'b0);
    feed(BYTE_LBRACK, 1'b0);
    feed(PARAM_HI, 1'b0);
    feed(BYTE_LOW_R, 1'b0);
    // CSI without parameters and another final: verbatim.
    feed(BYTE_ESC, 1'b0);
    feed(BYTE_LBRACK, 1'b0);
    feed(BYTE_LOW_M, 1'b0);
    // OSC closed by BEL.
    feed(BYTE_ESC, 1'b0);
    feed(BYTE_OSC, 1'b0);
    feed(BYTE_BEL, 1'b0);
    // DCS closed by ESC backslash.
    feed(BYTE_ESC, 1'b0);
    feed(BYTE_DCS, 1'b0);
    feed(BYTE_ESC, 1'b0);
    feed(BYTE_BSLASH, 1'b0);
    // APC cut short by a new CSI, which end of stream then flushes.
    feed(BYTE_ESC, 1'b0);
    feed(BYTE_APC, 1'b0);
    feed(BYTE_ESC, 1'b0);
    feed(BYTE_LBRACK, 1'b0);
    feed(BYTE_ZERO + 8'd2, 1'b0);
    feed(8'hA5, 1'b1);
    // Lone held ESC flushed, then end of stream with nothing held.
    feed(BYTE_ESC, 1'b0);
    feed(8'h5A, 1'b1);
    feed(8'h00, 1'b1);
    wait_drained();

    // Random phases over band settings, extremes first.
    tops    = '{10'd1, 10'd999, 10'd0, 10'd1000, 10'($urandom_range(1, 999))};
    bottoms = '{10'd999, 10'd1, 10'd1023, 10'd9, 10'($urandom_range(1, 999))};
    for (int p = 0; p < 5; p++) begin
      write_band(CFG_BAND_TOP, tops[p]);
      write_band(CFG_BAND_BOTTOM, bottoms[p]);
      burst_mode = (p == 2);
      target = fed_items + PHASE_ITEMS;
      // Open each phase with a CSI that spills the store.
      feed_csi($urandom_range(CSI_DEPTH + 1, CSI_DEPTH + 4), BYTE_LOW_R);
      while (fed_items < target) begin
        feed_random_sequence();
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(CLK_PERIOD * 1000000);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/essrc_pkg.sv
rtl/escape_stream_scroll_region_clamp.sv
sim/tb_escape_stream_scroll_region_clamp.sv
